// ===== sv/wbcs_pkg.sv =====
`default_nettype none

package wbcs_pkg;

  localparam int PIX_W    = 8;
  localparam int STRIDE_W = 13;
  localparam int OFFS_W   = 14;
  localparam int SPEED_W  = 13;
  localparam int TURN_W   = 16;
  localparam int COUNT_W  = 23;
  localparam int SUM_W    = 35;
  localparam int QC_W     = 15;

  localparam int DIV_DVD_W = SUM_W;
  localparam int DIV_DVS_W = COUNT_W;
  localparam int DIV_CNT_W = $clog2(DIV_DVD_W);

  localparam logic [PIX_W-1:0]    WHITE_LEVEL   = 8'hFF;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET  = 13'd2400;
  localparam logic [STRIDE_W-1:0] STRIDE_MIN    = 13'd3;
  localparam logic [STRIDE_W-1:0] MAX_ROW_BYTES = 13'd6144;
  localparam logic [STRIDE_W-1:0] MEAN_MAX      = 13'd8191;
  localparam logic [SPEED_W-1:0]  SPEED_Q14     = 13'd4915;
  localparam logic [QC_W-1:0]     Q14_ONE       = 15'd16384;
  localparam logic [COUNT_W-1:0]  COUNT_MAX     = {COUNT_W{1'b1}};
  localparam logic [SUM_W-1:0]    SUM_MAX       = {SUM_W{1'b1}};
  localparam logic [OFFS_W-1:0]   OFFS_NONE     = {OFFS_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_SETUP,
    ST_TURN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== sv/wbcs_div.sv =====
`default_nettype none

module wbcs_div
  import wbcs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [DIV_DVD_W-1:0] dividend,
  input  wire logic [DIV_DVS_W-1:0] divisor,
  output logic                      done,
  output logic      [DIV_DVD_W-1:0] quotient
);

  logic [DIV_DVS_W-1:0] rem;
  logic [DIV_DVS_W-1:0] dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 run;
  logic [DIV_DVS_W:0]   partial;
  logic [DIV_DVS_W+1:0] trial;

  assign partial = {rem, quotient[DIV_DVD_W-1]};
  assign trial   = {1'b0, partial} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_DVD_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (run) begin
      if (!trial[DIV_DVS_W+1]) begin
        rem      <= trial[DIV_DVS_W-1:0];
        quotient <= {quotient[DIV_DVD_W-2:0], 1'b1};
      end else begin
        rem      <= partial[DIV_DVS_W-1:0];
        quotient <= {quotient[DIV_DVD_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/white_blob_centroid_steer_core.sv =====
// Channel   Direction  Handshake                  Payload
// pixel     in         pixel_valid / pixel_stall  red, green, blue, frame_end
// result    out        result_valid / result_stall found, centroid_offset,
//                                                  forward_speed, turn_rate
// cfg       in         cfg_valid / cfg_ready      row_bytes
//
// Ordinary pixels transfer one per cycle while the core is idle. A frame_end pixel
// whose frame has white pixels off column zero holds pixel_stall through two passes
// of the shared radix-2 divider (mean, then turn rate), the setup state and the result load.
// A frame_end pixel without such white pixels stalls the input through the result load.
// Synchronous reset clears control state and loads row_bytes 2400.
// A stalled result holds in the output register and stretches the next result load.
`default_nettype none

module white_blob_centroid_steer_core
  import wbcs_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       pixel_valid,
  output logic                            pixel_stall,
  input  wire logic [PIX_W-1:0]           red,
  input  wire logic [PIX_W-1:0]           green,
  input  wire logic [PIX_W-1:0]           blue,
  input  wire logic                       frame_end,
  output logic                            result_valid,
  input  wire logic                       result_stall,
  output logic                            found,
  output logic signed [OFFS_W-1:0]        centroid_offset,
  output logic        [SPEED_W-1:0]       forward_speed,
  output logic signed [TURN_W-1:0]        turn_rate,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [STRIDE_W-1:0]        row_bytes
);

  state_t state, state_next;

  logic [STRIDE_W-1:0] stride_cfg;
  logic [STRIDE_W-1:0] stride;
  logic [STRIDE_W-1:0] stride_lat;
  logic [STRIDE_W-1:0] column_offset;
  logic [COUNT_W-1:0]  white_count;
  logic [SUM_W-1:0]    column_sum;
  logic [STRIDE_W-1:0] mean;
  logic                neg;
  logic                res_found;
  logic signed [TURN_W-1:0] res_turn;

  logic                pixel_xfer;
  logic                white;
  logic [SUM_W:0]      sum_add;
  logic [SUM_W-1:0]    sum_next;
  logic [COUNT_W-1:0]  count_next;
  logic [STRIDE_W:0]   off_add;
  logic [STRIDE_W-1:0] offset_next;
  logic                hit;
  logic                out_free;

  logic signed [QC_W-1:0] diff;
  logic [QC_W-2:0]        diff_mag;
  logic [2*(QC_W-1)-1:0]  num_mag;
  logic [QC_W-1:0]        q_turn;

  logic                 div_start;
  logic                 div_done;
  logic [DIV_DVD_W-1:0] div_dividend;
  logic [DIV_DVS_W-1:0] div_divisor;
  logic [DIV_DVD_W-1:0] div_quotient;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stride_cfg <= STRIDE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      stride_cfg <= row_bytes;
    end
  end

  always_comb begin
    if (stride_cfg < STRIDE_MIN) begin
      stride = STRIDE_MIN;
    end else if (stride_cfg > MAX_ROW_BYTES) begin
      stride = MAX_ROW_BYTES;
    end else begin
      stride = stride_cfg;
    end
  end

  assign pixel_xfer = pixel_valid && !pixel_stall;
  assign white      = (red == WHITE_LEVEL) && (green == WHITE_LEVEL) && (blue == WHITE_LEVEL);
  assign sum_add    = {1'b0, column_sum} + (SUM_W + 1)'(column_offset);

  always_comb begin
    sum_next   = column_sum;
    count_next = white_count;
    if (white) begin
      sum_next = (sum_add > {1'b0, SUM_MAX}) ? SUM_MAX : sum_add[SUM_W-1:0];
      if (white_count != COUNT_MAX) begin
        count_next = white_count + 1'b1;
      end
    end
  end

  assign off_add     = {1'b0, column_offset} + (STRIDE_W + 1)'(3);
  assign offset_next = (off_add >= {1'b0, stride}) ? '0 : off_add[STRIDE_W-1:0];
  assign hit         = (sum_next != '0) && (count_next != '0);
  assign out_free    = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_offset <= '0;
      white_count   <= '0;
      column_sum    <= '0;
    end else if (pixel_xfer) begin
      if (frame_end) begin
        column_offset <= '0;
        white_count   <= '0;
        column_sum    <= '0;
      end else begin
        column_offset <= offset_next;
        white_count   <= count_next;
        column_sum    <= sum_next;
      end
    end
  end

  assign diff     = $signed({2'b00, stride_lat}) - $signed({1'b0, mean, 1'b0});
  assign diff_mag = diff[QC_W-1] ? (QC_W-1)'(-diff) : diff[QC_W-2:0];
  assign num_mag  = {diff_mag, {(QC_W-1){1'b0}}};
  assign q_turn   = (div_quotient > DIV_DVD_W'(Q14_ONE)) ? Q14_ONE : div_quotient[QC_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (pixel_xfer && frame_end) begin
          state_next = hit ? ST_MEAN : ST_DONE;
        end
      end
      ST_MEAN: begin
        if (div_done) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: state_next = ST_TURN;
      ST_TURN: begin
        if (div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pixel_stall  = 1'b1;
    div_start    = 1'b0;
    div_dividend = sum_next;
    div_divisor  = count_next;
    case (state)
      ST_IDLE: begin
        pixel_stall = 1'b0;
        div_start   = pixel_valid && frame_end && hit;
      end
      ST_SETUP: begin
        div_start    = 1'b1;
        div_dividend = DIV_DVD_W'(num_mag);
        div_divisor  = DIV_DVS_W'(stride_lat);
      end
      default: begin
        pixel_stall = 1'b1;
      end
    endcase
  end

  wbcs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (pixel_xfer && frame_end) begin
          stride_lat <= stride;
          res_found  <= hit;
        end
      end
      ST_MEAN: begin
        if (div_done) begin
          mean <= (div_quotient > DIV_DVD_W'(MEAN_MAX)) ?
                  MEAN_MAX : div_quotient[STRIDE_W-1:0];
        end
      end
      ST_SETUP: neg <= diff[QC_W-1];
      ST_TURN: begin
        if (div_done) begin
          res_turn <= neg ? -$signed({1'b0, q_turn}) : $signed({1'b0, q_turn});
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      found           <= res_found;
      centroid_offset <= res_found ? $signed({1'b0, mean}) : $signed(OFFS_NONE);
      forward_speed   <= res_found ? SPEED_Q14 : '0;
      turn_rate       <= res_found ? res_turn : '0;
    end
  end

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_DONE))
    else $error("result raised outside result load");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_MEAN || state == ST_TURN))
    else $error("divider finished outside a divide state");

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    pixel_xfer && frame_end |=>
      (white_count == '0 && column_sum == '0 && column_offset == '0))
    else $error("accumulators not cleared after frame end");

  a_found_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && found |-> (forward_speed == SPEED_Q14 && !centroid_offset[OFFS_W-1]))
    else $error("found result carries wrong speed or negative offset");

endmodule

`default_nettype wire

// ===== verif/wbcs_steer_checker.sv =====
`timescale 1ns / 1ps

module wbcs_steer_checker
  import wbcs_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pixel_valid,
  input  logic                      pixel_stall,
  input  logic [PIX_W-1:0]          red,
  input  logic [PIX_W-1:0]          green,
  input  logic [PIX_W-1:0]          blue,
  input  logic                      frame_end,
  input  logic                      result_valid,
  input  logic                      result_stall,
  input  logic                      found,
  input  logic signed [OFFS_W-1:0]  centroid_offset,
  input  logic [SPEED_W-1:0]        forward_speed,
  input  logic signed [TURN_W-1:0]  turn_rate,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [STRIDE_W-1:0]       row_bytes,
  output int                        fail_count,
  output int                        pending
);

  localparam logic [STRIDE_W-1:0] RESET_STRIDE = 13'd2400;
  localparam longint unsigned     ROW_MIN      = 3;
  localparam longint unsigned     ROW_MAX      = 6144;
  localparam longint unsigned     MEAN_CAP     = 8191;
  localparam longint unsigned     SUM_CAP      = (64'd1 << 35) - 64'd1;
  localparam longint              Q14          = 16384;
  localparam logic [SPEED_W-1:0]  CRUISE_Q14   = 13'd4915;

  typedef struct packed {
    logic                     found;
    logic signed [OFFS_W-1:0] offset;
    logic [SPEED_W-1:0]       speed;
    logic signed [TURN_W-1:0] turn;
  } steer_t;

  steer_t              steer_q[$];
  logic [STRIDE_W-1:0] stride_reg;
  logic [STRIDE_W-1:0] col_pos;
  logic [22:0]         white_n;
  logic [34:0]         white_sum;

  initial fail_count = 0;
  initial pending = 0;

  task automatic track_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                             input logic [PIX_W-1:0] b, input logic last);
    longint unsigned s;
    longint unsigned nxt;
    longint unsigned acc;
    longint unsigned mean;
    longint          num;
    longint          turn;
    steer_t          res;
    s = longint'(stride_reg);
    if (s < ROW_MIN) s = ROW_MIN;
    if (s > ROW_MAX) s = ROW_MAX;
    if (r == 8'hFF && g == 8'hFF && b == 8'hFF) begin
      if (white_n != '1) white_n = white_n + 1'b1;
      acc = longint'(white_sum) + longint'(col_pos);
      if (acc > SUM_CAP) acc = SUM_CAP;
      white_sum = 35'(acc);
    end
    nxt = longint'(col_pos) + 3;
    col_pos = (nxt >= s) ? '0 : STRIDE_W'(nxt);
    if (last) begin
      if (white_sum == 0 || white_n == 0) begin
        res.found  = 1'b0;
        res.offset = '1;
        res.speed  = '0;
        res.turn   = '0;
      end else begin
        mean = longint'(white_sum) / longint'(white_n);
        if (mean > MEAN_CAP) mean = MEAN_CAP;
        num  = (longint'(s) - 2 * longint'(mean)) * Q14;
        turn = num / longint'(s);
        if (turn > Q14) turn = Q14;
        if (turn < -Q14) turn = -Q14;
        res.found  = 1'b1;
        res.offset = OFFS_W'(mean);
        res.speed  = CRUISE_Q14;
        res.turn   = TURN_W'(turn);
      end
      steer_q.push_back(res);
      col_pos   = '0;
      white_n   = '0;
      white_sum = '0;
    end
  endtask

  task automatic check_field(input string fname, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s expected %0d actual %0d", fname, want, got);
      fail_count++;
    end
  endtask

  task automatic check_steer();
    steer_t want;
    if (steer_q.size() == 0) begin
      $error("result transfer with nothing expected: found %0d offset %0d turn %0d",
             found, centroid_offset, turn_rate);
      fail_count++;
    end else begin
      want = steer_q.pop_front();
      check_field("found", 32'(want.found), 32'(found));
      check_field("centroid_offset", 32'(want.offset), 32'(centroid_offset));
      check_field("forward_speed", 32'(want.speed), 32'(forward_speed));
      check_field("turn_rate", 32'(want.turn), 32'(turn_rate));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      steer_q.delete();
      stride_reg = RESET_STRIDE;
      col_pos    = '0;
      white_n    = '0;
      white_sum  = '0;
    end else begin
      if (result_valid && !result_stall) check_steer();
      if (pixel_valid && !pixel_stall) track_pixel(red, green, blue, frame_end);
      if (cfg_valid && cfg_ready) stride_reg = row_bytes;
    end
    pending = steer_q.size();
  end

endmodule

// ===== verif/tb_white_blob_centroid_steer_core.sv =====
`timescale 1ns / 1ps

module tb_white_blob_centroid_steer_core;
  import wbcs_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 80;
  localparam int PHASE_ITEMS    = 100;

  logic                     clk;
  logic                     rst;
  logic                     pixel_valid;
  logic                     pixel_stall;
  logic [PIX_W-1:0]         red;
  logic [PIX_W-1:0]         green;
  logic [PIX_W-1:0]         blue;
  logic                     frame_end;
  logic                     result_valid;
  logic                     result_stall;
  logic                     found;
  logic signed [OFFS_W-1:0] centroid_offset;
  logic [SPEED_W-1:0]       forward_speed;
  logic signed [TURN_W-1:0] turn_rate;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [STRIDE_W-1:0]      row_bytes;

  int fail_count;
  int pending;
  int quiet_cycles = 0;
  int hold_left    = 0;
  bit hold_req     = 1'b0;
  bit pix_gaps     = 1'b1;
  bit res_gaps     = 1'b1;

  white_blob_centroid_steer_core u_top (
    .clk(clk), .rst(rst),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
    .red(red), .green(green), .blue(blue), .frame_end(frame_end),
    .result_valid(result_valid), .result_stall(result_stall),
    .found(found), .centroid_offset(centroid_offset),
    .forward_speed(forward_speed), .turn_rate(turn_rate),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .row_bytes(row_bytes)
  );

  wbcs_steer_checker u_checker (
    .clk(clk), .rst(rst),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
    .red(red), .green(green), .blue(blue), .frame_end(frame_end),
    .result_valid(result_valid), .result_stall(result_stall),
    .found(found), .centroid_offset(centroid_offset),
    .forward_speed(forward_speed), .turn_rate(turn_rate),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .row_bytes(row_bytes),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= res_gaps && ($urandom_range(0, 99) < 28);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                            input logic [PIX_W-1:0] b, input logic last);
    while (pix_gaps && $urandom_range(0, 99) < 28) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    red         <= r;
    green       <= g;
    blue        <= b;
    frame_end   <= last;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
  endtask

  task automatic send_random_pixel(input logic last);
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
    r = PIX_W'($urandom_range(0, 255));
    g = PIX_W'($urandom_range(0, 255));
    b = PIX_W'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        r = 8'hFF;
        g = 8'hFF;
        b = 8'hFF;
      end
      4: begin
        r = 8'hFF;
        g = 8'hFF;
      end
      default: ;
    endcase
    send_pixel(r, g, b, last);
  endtask

  // hold input, wait out every pending result and the divider tail
  task automatic drain();
    pixel_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_stride(input logic [STRIDE_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    row_bytes <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(input int len);
    for (int k = 0; k < len; k++) send_random_pixel(k == len - 1);
  endtask

  initial begin
    int sent;
    int len;
    logic [STRIDE_W-1:0] stride_pick;
    rst          <= 1'b1;
    pixel_valid  <= 1'b0;
    red          <= '0;
    green        <= '0;
    blue         <= '0;
    frame_end    <= 1'b0;
    cfg_valid    <= 1'b0;
    row_bytes    <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // white only in column zero reads as not found
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    // near-white pixels around real white ones
    send_pixel(8'hFF, 8'hFF, 8'hFE, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'hFE, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);

    write_stride(13'd3);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);

    write_stride(13'd7);
    repeat (3) send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);

    // stride drop mid frame drives the turn rate into saturation
    write_stride(13'd30);
    repeat (6) send_pixel(8'h10, 8'hFF, 8'hFF, 1'b0);
    repeat (4) send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    write_stride(13'd0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);

    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0:       stride_pick = 13'd6144;
        1:       stride_pick = 13'd8191;
        2:       stride_pick = 13'd1;
        3:       stride_pick = 13'd2400;
        4:       stride_pick = 13'd30;
        5:       stride_pick = 13'd99;
        6:       stride_pick = STRIDE_W'($urandom_range(3, 60));
        7:       stride_pick = 13'd2;
        8:       stride_pick = STRIDE_W'($urandom_range(0, 8191));
        9:       stride_pick = 13'd100;
        10:      stride_pick = 13'd4;
        default: stride_pick = STRIDE_W'($urandom_range(3, 300));
      endcase
      write_stride(stride_pick);
      pix_gaps = (ph != 3);
      res_gaps = (ph != 3);
      if (ph == 6) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
        send_frame(len);
        sent += len;
      end
      // leave a frame open across the next stride write
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 10)) send_random_pixel(1'b0);
    end

    drain();
    if (fail_count == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/wbcs_pkg.sv
sv/wbcs_div.sv
sv/white_blob_centroid_steer_core.sv
verif/wbcs_steer_checker.sv
verif/tb_white_blob_centroid_steer_core.sv
